FILE: hw/rtl/pid_controller_clamped_defines.svh
// Assertion macros for the port-level checks of the PID controller.
// Needs nothing else; files that assert take it in by include.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Assertion that is switched off while reset is asserted.
`define PCC_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcc assertion failed");

// Assertion that is checked at every edge, reset included.
`define PCC_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcc assertion failed");

`endif

FILE: hw/rtl/pcc_pkg.sv
// Package of the clamped PID controller: widths, register indexes, state codes
// and the command and status structs between controller and datapath.
// Needs nothing else.
package pcc_pkg;

    localparam int MEAS_W      = 32;
    localparam int GAIN_W      = 24;
    localparam int DT_W        = 16;
    localparam int ERR_W       = 33;
    localparam int DIFF_W      = 34;
    localparam int DERIV_W     = 40;
    localparam int DT_SHIFT    = 8;
    localparam int DIV_W       = DIFF_W + DT_SHIFT;
    localparam int DIV_CNT_W   = 6;
    localparam int INC_W       = 41;
    localparam int GAIN_SHIFT  = 16;
    localparam int MUL_A_W     = GAIN_W + 1;
    localparam int MUL_B_W     = 64;
    localparam int MUL_CHUNK   = 32;
    localparam int MUL_P_W     = MUL_A_W + MUL_CHUNK + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_POINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_DIFF, S_INC_H, S_INC_A, S_INTEG,
        S_P_H, S_P_A, S_P_USE, S_I_H, S_I_A, S_I_USE,
        S_WAIT_DIV, S_D_L, S_D_H, S_D_A, S_D_USE,
        S_CLAMP_HI, S_CLAMP_LO, S_OUT
    } t_state;

    typedef enum logic [1:0] {MS_INC, MS_P, MS_I, MS_D} t_msrc;
    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD} t_acc;
    typedef enum logic [1:0] {SUM_NONE, SUM_LOAD, SUM_ADD} t_sum;

    typedef struct packed {
        logic  load_in;
        logic  calc_err;
        logic  div_start;
        logic  mul_en;
        t_msrc mul_src;
        logic  mul_hi;
        t_acc  acc_op;
        logic  integ;
        t_sum  sum_op;
        logic  deriv_load;
        logic  clamp_hi;
        logic  clamp_lo;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

FILE: hw/rtl/pcc_if.sv
// Valid/ready channel interfaces for the input and result items of the
// clamped PID controller. Depends on pcc_pkg for the field widths.
interface pcc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::MEAS_W-1:0]   measured;
    logic        [pcc_pkg::DT_W-1:0]     step_time;
    logic                                restart;

    modport source (output valid, measured, step_time, restart, input ready);
    modport sink   (input valid, measured, step_time, restart, output ready);
endinterface

interface pcc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::MEAS_W-1:0]   drive;
    logic                                hit_high;
    logic                                hit_low;

    modport source (output valid, drive, hit_high, hit_low, input ready);
    modport sink   (input valid, drive, hit_high, hit_low, output ready);
endinterface

FILE: hw/rtl/pcc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pcc_pkg for its widths.
module pcc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcc_pkg::DIV_W-1:0]     i_dividend,
    input  logic [pcc_pkg::DT_W-1:0]      i_divisor,
    output logic                          o_busy,
    output logic [pcc_pkg::DIV_W-1:0]     o_quotient
);

    logic [pcc_pkg::DIV_W-1:0]      r_quo;
    logic [pcc_pkg::DT_W-1:0]       r_rem;
    logic [pcc_pkg::DT_W-1:0]       r_dvs;
    logic [pcc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic [pcc_pkg::DT_W:0]         w_trial;
    logic [pcc_pkg::DT_W:0]         w_sub;
    logic                           w_bit;

    always_comb begin
        w_trial = {r_rem, r_quo[pcc_pkg::DIV_W-1]};
        w_sub   = w_trial - {1'b0, r_dvs};
        w_bit   = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pcc_pkg::DIV_CNT_W'(pcc_pkg::DIV_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != pcc_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pcc_pkg::DIV_W-2:0], w_bit};
            r_rem <= w_bit ? w_sub[pcc_pkg::DT_W-1:0] : w_trial[pcc_pkg::DT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/pcc_dp.sv
// Datapath of the clamped PID controller: configuration registers, loop state,
// shared multiplier with product accumulator, divider and clamp.
// Depends on pcc_pkg and pcc_div.
module pcc_dp #(
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [pcc_pkg::MEAS_W-1:0]     i_measured,
    input  logic [pcc_pkg::DT_W-1:0]              i_step_time,
    input  logic                                  i_restart,
    input  pcc_pkg::t_cmd                         i_cmd,
    output pcc_pkg::t_sts                         o_sts,
    output logic signed [pcc_pkg::MEAS_W-1:0]     o_drive,
    output logic                                  o_hit_high,
    output logic                                  o_hit_low
);

    localparam int IW     = INTEGRAL_WIDTH;
    localparam int ISUM_W = IW + 2;
    localparam int SUM_W  = IW + 10;
    localparam logic signed [ISUM_W-1:0] IMAX = ISUM_W'({1'b0, {(IW-1){1'b1}}});
    localparam logic signed [ISUM_W-1:0] IMIN = ~IMAX;
    localparam logic [pcc_pkg::DIV_W-1:0] DERIV_LIM =
        pcc_pkg::DIV_W'(1) << (pcc_pkg::DERIV_W - 1);

    logic signed [pcc_pkg::GAIN_W-1:0]   r_gain_p;
    logic signed [pcc_pkg::GAIN_W-1:0]   r_gain_i;
    logic signed [pcc_pkg::GAIN_W-1:0]   r_gain_d;
    logic signed [pcc_pkg::MEAS_W-1:0]   r_set_point;
    logic signed [pcc_pkg::MEAS_W-1:0]   r_out_min;
    logic signed [pcc_pkg::MEAS_W-1:0]   r_out_max;

    logic signed [pcc_pkg::ERR_W-1:0]    r_prev;
    logic signed [IW-1:0]                r_integ;
    logic                                r_clamped_upper;
    logic                                r_clamped_lower;

    logic signed [pcc_pkg::MEAS_W-1:0]   r_meas;
    logic [pcc_pkg::DT_W-1:0]            r_dt;
    logic                                r_restart;
    logic signed [pcc_pkg::ERR_W-1:0]    r_err;
    logic                                r_diff_neg;
    logic signed [pcc_pkg::DERIV_W-1:0]  r_deriv;
    logic signed [pcc_pkg::MUL_P_W-1:0]  r_mul;
    logic signed [pcc_pkg::PROD_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]             r_sum;
    logic                                r_hh;
    logic                                r_hl;
    logic signed [pcc_pkg::MEAS_W-1:0]   r_drive;
    logic                                r_hit_high;
    logic                                r_hit_low;

    logic signed [pcc_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [pcc_pkg::MUL_B_W-1:0]   w_b64;
    logic signed [pcc_pkg::MUL_CHUNK:0]   w_mul_b;
    logic signed [pcc_pkg::DIFF_W-1:0]    w_diff;
    logic [pcc_pkg::DIFF_W-1:0]           w_diff_mag;
    logic [pcc_pkg::DT_W-1:0]             w_divisor;
    logic [pcc_pkg::DIV_W-1:0]            w_quo;
    logic                                 w_div_busy;
    logic signed [pcc_pkg::DERIV_W-1:0]   w_deriv;
    logic signed [pcc_pkg::INC_W-1:0]     w_inc;
    logic signed [ISUM_W-1:0]             w_isum;
    logic signed [IW-1:0]                 w_integ_next;
    logic                                 w_do_integ;
    logic signed [SUM_W-1:0]              w_term;
    logic signed [SUM_W-1:0]              w_max;
    logic signed [SUM_W-1:0]              w_min;
    logic                                 w_err_pos;
    logic                                 w_err_neg;
    logic                                 w_ki_pos;
    logic                                 w_ki_neg;

    always_comb begin
        unique case (i_cmd.mul_src)
            pcc_pkg::MS_INC: begin
                w_mul_a = {{(pcc_pkg::MUL_A_W - pcc_pkg::DT_W){1'b0}}, w_divisor};
                w_b64   = pcc_pkg::MUL_B_W'(r_err);
            end
            pcc_pkg::MS_P: begin
                w_mul_a = pcc_pkg::MUL_A_W'(r_gain_p);
                w_b64   = pcc_pkg::MUL_B_W'(r_err);
            end
            pcc_pkg::MS_I: begin
                w_mul_a = pcc_pkg::MUL_A_W'(r_gain_i);
                w_b64   = pcc_pkg::MUL_B_W'(r_integ);
            end
            pcc_pkg::MS_D: begin
                w_mul_a = pcc_pkg::MUL_A_W'(r_gain_d);
                w_b64   = pcc_pkg::MUL_B_W'(r_deriv);
            end
            default: begin
                w_mul_a = '0;
                w_b64   = '0;
            end
        endcase
        if (i_cmd.mul_hi) begin
            w_mul_b = {w_b64[pcc_pkg::MUL_B_W-1],
                       w_b64[pcc_pkg::MUL_B_W-1:pcc_pkg::MUL_CHUNK]};
        end else begin
            w_mul_b = {1'b0, w_b64[pcc_pkg::MUL_CHUNK-1:0]};
        end
    end

    always_comb begin
        w_diff     = pcc_pkg::DIFF_W'(r_err) - pcc_pkg::DIFF_W'(r_prev);
        w_diff_mag = w_diff[pcc_pkg::DIFF_W-1] ? -w_diff : w_diff;
        w_divisor  = (r_dt == '0) ? pcc_pkg::DT_W'(1) : r_dt;
    end

    pcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_diff_mag, {pcc_pkg::DT_SHIFT{1'b0}}}),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign o_sts.div_busy = w_div_busy;

    always_comb begin
        w_deriv = w_quo[pcc_pkg::DERIV_W-1:0];
        if (r_diff_neg) begin
            if (w_quo > DERIV_LIM) begin
                w_deriv = {1'b1, {(pcc_pkg::DERIV_W-1){1'b0}}};
            end else begin
                w_deriv = -w_quo[pcc_pkg::DERIV_W-1:0];
            end
        end else if (w_quo >= DERIV_LIM) begin
            w_deriv = {1'b0, {(pcc_pkg::DERIV_W-1){1'b1}}};
        end
    end

    always_comb begin
        w_err_pos  = !r_err[pcc_pkg::ERR_W-1] && (r_err != '0);
        w_err_neg  = r_err[pcc_pkg::ERR_W-1];
        w_ki_pos   = !r_gain_i[pcc_pkg::GAIN_W-1] && (r_gain_i != '0);
        w_ki_neg   = r_gain_i[pcc_pkg::GAIN_W-1];
        w_do_integ = (((w_err_pos && w_ki_pos) || (w_err_neg && w_ki_neg)) && !r_clamped_upper)
                  || (((w_err_pos && w_ki_neg) || (w_err_neg && w_ki_pos)) && !r_clamped_lower);
        w_inc      = pcc_pkg::INC_W'(r_prod >>> pcc_pkg::DT_SHIFT);
        w_isum     = ISUM_W'(r_integ) + ISUM_W'(w_inc);
        if (w_isum > IMAX) begin
            w_integ_next = IMAX[IW-1:0];
        end else if (w_isum < IMIN) begin
            w_integ_next = IMIN[IW-1:0];
        end else begin
            w_integ_next = w_isum[IW-1:0];
        end
        w_term = SUM_W'(r_prod >>> pcc_pkg::GAIN_SHIFT);
        w_max  = SUM_W'(r_out_max);
        w_min  = SUM_W'(r_out_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_set_point <= '0;
            r_out_min   <= {1'b1, {(pcc_pkg::MEAS_W-1){1'b0}}};
            r_out_max   <= {1'b0, {(pcc_pkg::MEAS_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcc_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_data[pcc_pkg::GAIN_W-1:0];
                pcc_pkg::CFG_GAIN_I:    r_gain_i    <= i_cfg_data[pcc_pkg::GAIN_W-1:0];
                pcc_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_data[pcc_pkg::GAIN_W-1:0];
                pcc_pkg::CFG_SET_POINT: r_set_point <= i_cfg_data;
                pcc_pkg::CFG_OUT_MIN:   r_out_min   <= i_cfg_data;
                pcc_pkg::CFG_OUT_MAX:   r_out_max   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev          <= '0;
            r_integ         <= '0;
            r_clamped_upper <= 1'b0;
            r_clamped_lower <= 1'b0;
        end else if (i_cmd.calc_err && r_restart) begin
            r_prev          <= '0;
            r_integ         <= '0;
            r_clamped_upper <= 1'b0;
            r_clamped_lower <= 1'b0;
        end else if (i_cmd.integ && w_do_integ) begin
            r_integ <= w_integ_next;
        end else if (i_cmd.out_load) begin
            r_prev          <= r_err;
            r_clamped_upper <= r_hh;
            r_clamped_lower <= r_hl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas    <= i_measured;
            r_dt      <= i_step_time;
            r_restart <= i_restart;
        end
        if (i_cmd.calc_err) begin
            r_err <= pcc_pkg::ERR_W'(r_set_point) - pcc_pkg::ERR_W'(r_meas);
        end
        if (i_cmd.div_start) begin
            r_diff_neg <= w_diff[pcc_pkg::DIFF_W-1];
        end
        if (i_cmd.deriv_load) begin
            r_deriv <= w_deriv;
        end
        if (i_cmd.mul_en) begin
            r_mul <= w_mul_a * w_mul_b;
        end
        unique case (i_cmd.acc_op)
            pcc_pkg::ACC_LOAD: r_prod <= pcc_pkg::PROD_W'(r_mul);
            pcc_pkg::ACC_ADD:  r_prod <= r_prod + (pcc_pkg::PROD_W'(r_mul) <<< pcc_pkg::MUL_CHUNK);
            default: begin
            end
        endcase
        priority if (i_cmd.sum_op == pcc_pkg::SUM_LOAD) begin
            r_sum <= w_term;
        end else if (i_cmd.sum_op == pcc_pkg::SUM_ADD) begin
            r_sum <= r_sum + w_term;
        end else if (i_cmd.clamp_hi) begin
            r_hh <= (r_sum >= w_max);
            if (r_sum >= w_max) begin
                r_sum <= w_max;
            end
        end else if (i_cmd.clamp_lo) begin
            r_hl <= (r_sum <= w_min);
            if (r_sum <= w_min) begin
                r_sum <= w_min;
            end
        end
        if (i_cmd.out_load) begin
            r_drive    <= r_sum[pcc_pkg::MEAS_W-1:0];
            r_hit_high <= r_hh;
            r_hit_low  <= r_hl;
        end
    end

    assign o_drive    = r_drive;
    assign o_hit_high = r_hit_high;
    assign o_hit_low  = r_hit_low;

endmodule

FILE: hw/rtl/pcc_ctrl.sv
// Sequencer of the clamped PID controller: steps the datapath through one item
// and owns the input ready and the result valid. Depends on pcc_pkg.
module pcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  pcc_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output pcc_pkg::t_cmd  o_cmd
);

    pcc_pkg::t_state r_state;
    pcc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pcc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = pcc_pkg::S_ERR;
                end
            end
            pcc_pkg::S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = pcc_pkg::S_DIFF;
            end
            pcc_pkg::S_DIFF: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_src   = pcc_pkg::MS_INC;
                n_state = pcc_pkg::S_INC_H;
            end
            pcc_pkg::S_INC_H: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_INC;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.acc_op  = pcc_pkg::ACC_LOAD;
                n_state = pcc_pkg::S_INC_A;
            end
            pcc_pkg::S_INC_A: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
                n_state = pcc_pkg::S_INTEG;
            end
            pcc_pkg::S_INTEG: begin
                o_cmd.integ   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_P;
                n_state = pcc_pkg::S_P_H;
            end
            pcc_pkg::S_P_H: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_P;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.acc_op  = pcc_pkg::ACC_LOAD;
                n_state = pcc_pkg::S_P_A;
            end
            pcc_pkg::S_P_A: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
                n_state = pcc_pkg::S_P_USE;
            end
            pcc_pkg::S_P_USE: begin
                o_cmd.sum_op  = pcc_pkg::SUM_LOAD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_I;
                n_state = pcc_pkg::S_I_H;
            end
            pcc_pkg::S_I_H: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_I;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.acc_op  = pcc_pkg::ACC_LOAD;
                n_state = pcc_pkg::S_I_A;
            end
            pcc_pkg::S_I_A: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
                n_state = pcc_pkg::S_I_USE;
            end
            pcc_pkg::S_I_USE: begin
                o_cmd.sum_op = pcc_pkg::SUM_ADD;
                n_state = pcc_pkg::S_WAIT_DIV;
            end
            pcc_pkg::S_WAIT_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.deriv_load = 1'b1;
                    n_state = pcc_pkg::S_D_L;
                end
            end
            pcc_pkg::S_D_L: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_D;
                n_state = pcc_pkg::S_D_H;
            end
            pcc_pkg::S_D_H: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = pcc_pkg::MS_D;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.acc_op  = pcc_pkg::ACC_LOAD;
                n_state = pcc_pkg::S_D_A;
            end
            pcc_pkg::S_D_A: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
                n_state = pcc_pkg::S_D_USE;
            end
            pcc_pkg::S_D_USE: begin
                o_cmd.sum_op = pcc_pkg::SUM_ADD;
                n_state = pcc_pkg::S_CLAMP_HI;
            end
            pcc_pkg::S_CLAMP_HI: begin
                o_cmd.clamp_hi = 1'b1;
                n_state = pcc_pkg::S_CLAMP_LO;
            end
            pcc_pkg::S_CLAMP_LO: begin
                o_cmd.clamp_lo = 1'b1;
                n_state = pcc_pkg::S_OUT;
            end
            pcc_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = pcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcc_pkg::S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/pid_controller_clamped.sv
// Top level of the clamped PID controller with conditional integration.
// Depends on pcc_pkg, pcc_if, pcc_ctrl, pcc_dp and pcc_div.
//
//   port       dir  kind        content
//   i_in       in   valid/ready measured, step_time, restart
//   o_out      out  valid/ready drive, hit_high, hit_low
//   i_cfg_*    in   write only  gain_p, gain_i, gain_d, set_point, out_min, out_max
//
// One item at a time; the next item can be taken in the same cycle in which the
// result of the last one becomes valid. The 42-step serial divider for the
// derivative runs alongside the products on one shared multiplier, and the
// sequencer waits for it before the derivative term.
// Reset is synchronous and returns the configuration registers and loop state to their defaults.
// A stalled result waits in the output register while the next item is taken.
module pid_controller_clamped #(
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pcc_in_if.sink                              i_in,
    pcc_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    pcc_pkg::t_cmd w_cmd;
    pcc_pkg::t_sts w_sts;
    logic          w_in_ready;
    logic          w_out_valid;

    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    pcc_dp #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_measured  (i_in.measured),
        .i_step_time (i_in.step_time),
        .i_restart   (i_in.restart),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_drive     (o_out.drive),
        .o_hit_high  (o_out.hit_high),
        .o_hit_low   (o_out.hit_low)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

FILE: hw/rtl/pcc_chk.sv
// Port-level checks of the clamped PID controller, bound to the top level.
// Depends on pid_controller_clamped_defines.svh and pcc_pkg.
`include "pid_controller_clamped_defines.svh"

module pcc_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [pcc_pkg::MEAS_W-1:0]  i_drive,
    input logic                               i_hit_high,
    input logic                               i_hit_low
);

    `PCC_ASSERT_ALL(a_rst_no_result, i_clk, !i_rst_n |=> !i_out_valid)
    `PCC_ASSERT_RST(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    `PCC_ASSERT_RST(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !$rose(i_out_valid))
    `PCC_ASSERT_RST(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive) && $stable(i_hit_high) && $stable(i_hit_low))

endmodule

bind pid_controller_clamped pcc_chk u_pcc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive),
    .i_hit_high  (o_out.hit_high),
    .i_hit_low   (o_out.hit_low)
);
